// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  `ASSERT_PROP(label, clk, rst_n, (pre) |-> (post), msg)

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Payload types, pipeline payloads and arithmetic constants.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Hue in 1/64 degree, one full turn and one sixty degree sector.
  localparam logic [14:0] HUE_FULL_TURN = 15'd23040;
  localparam logic [11:0] SECTOR_STEPS  = 12'd3840;

  // Fraction one for saturation and value.
  localparam logic [7:0]  FRACTION_ONE  = 8'd255;

  // Denominator of q and t: 255 * 3840.
  localparam logic [19:0] DEN_QT        = 20'd979200;

  // After a right shift by 8 the q and t divisor is 255 * 15.
  localparam logic [11:0] DIV_QT        = 12'd3825;

  // Reciprocals: floor(2^20 / 3825) and floor(2^16 / 255).
  localparam logic [8:0]  RECIP_QT      = 9'd274;
  localparam logic [8:0]  RECIP_P       = 9'd257;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } hsv_sector_e;

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic [7:0]  alpha_in;
  } hsv_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } rgb_out_t;

  // Sector split of the hue.
  typedef struct packed {
    hsv_sector_e sector;
    logic [11:0] rem;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } hsv_sec_t;

  // Dividends of p, q and t; q and t already shifted right by 8.
  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [19:0] num_q;
    logic [19:0] num_t;
    logic [15:0] num_p;
  } hsv_prod_t;

  // Finished channel candidates.
  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [7:0]  q;
    logic [7:0]  t;
    logic [7:0]  p;
  } hsv_quot_t;

endpackage

// ===== design/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Nine-stage pipeline turning one HSV pixel with alpha into 8-bit RGBA.
// ----------------------------------------------------------------------------
// The input channel carries one pixel per transfer: hue in 1/64 degree,
// saturation, brightness and alpha. A transfer happens on a rising clock edge
// where in_valid_i is high and in_stall_o is low. The output channel carries
// red, green, blue and the unchanged alpha, with a transfer on an edge where
// out_valid_o is high and out_stall_i is low. Every input transfer yields
// exactly one output transfer, in order.
// A pixel passes through nine register stages, each of which holds one
// pixel: hue wrap, sector split, saturation products, scaled factors,
// value products, reciprocal estimate, remainder, correction and the
// output register. Throughput is one pixel per clock while out_stall_i
// stays low.
// Reset clears the valid bits of all stages only; the pipeline is then empty
// and accepts a pixel as soon as reset is released.
// When the receiver stalls, the output register holds its pixel. Each stage
// keeps moving as long as the stage after it is empty or moving, so bubbles
// close up, and in_stall_o rises only once every stage holds a pixel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter_unit import hsv2rgb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hsv_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rgb_out_t out_data_o
);

  // Inter-module links; each stall travels against the valid of its link.
  logic      sec_valid, sec_stall;
  hsv_sec_t  sec_data;
  logic      prod_valid, prod_stall;
  hsv_prod_t prod_data;
  logic      div_valid, div_stall;
  hsv_quot_t div_data;

  // Hue wrap and sector with remainder inside the sector.
  hsv2rgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (sec_valid),
    .stall_i (sec_stall),
    .data_o  (sec_data)
  );

  // Dividends of p, q and t.
  hsv2rgb_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sec_valid),
    .stall_o (sec_stall),
    .data_i  (sec_data),
    .valid_o (prod_valid),
    .stall_i (prod_stall),
    .data_o  (prod_data)
  );

  // Exact truncating division by constants through reciprocal multiplication.
  hsv2rgb_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .stall_o (prod_stall),
    .data_i  (prod_data),
    .valid_o (div_valid),
    .stall_i (div_stall),
    .data_o  (div_data)
  );

  // Channel order by sector, then the output register.
  hsv2rgb_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .stall_o (div_stall),
    .data_i  (div_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // The input is held back only while a finished pixel waits at the output.
  `ASSERT_IMPLY(a_in_stall_cause, clk_i, rst_ni, in_stall_o,
                out_valid_o && out_stall_i, "input stalled without output stall")

  // Each of p, q and t is v scaled by a factor of at most one.
  `ASSERT_IMPLY(a_div_bound, clk_i, rst_ni, div_valid,
                (div_data.p <= div_data.val) && (div_data.q <= div_data.val) &&
                (div_data.t <= div_data.val), "divider result exceeds value")

  // A stall on the divider output means the output register is full and held.
  `ASSERT_IMPLY(a_div_stall_cause, clk_i, rst_ni, div_stall,
                out_valid_o && out_stall_i,
                "divider stalled without a full output stage")

endmodule

// ===== design/hsv2rgb_sector.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB sector split
// Two stages: wraps the hue into one turn, then finds sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_sector import hsv2rgb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  hsv_in_t  data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output hsv_sec_t data_o
);

  typedef struct packed {
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [7:0]  alpha;
  } wrap_t;

  logic     va_q, vb_q;
  logic     stall_a, stall_b;
  wrap_t    wrap_d, wrap_q;
  hsv_sec_t sec_d, sec_q;
  logic [14:0] base;

  assign stall_b = vb_q && stall_i;
  assign stall_a = va_q && stall_b;
  assign stall_o = stall_a;

  // A hue past one turn needs a single subtraction.
  always_comb begin
    wrap_d.hue   = (data_i.hue >= HUE_FULL_TURN) ? (data_i.hue - HUE_FULL_TURN)
                                                 : data_i.hue;
    wrap_d.sat   = data_i.saturation;
    wrap_d.val   = data_i.brightness;
    wrap_d.alpha = data_i.alpha_in;
  end

  always_comb begin
    if (wrap_q.hue >= 15'd19200) begin
      sec_d.sector = SECTOR_5;
      base         = 15'd19200;
    end else if (wrap_q.hue >= 15'd15360) begin
      sec_d.sector = SECTOR_4;
      base         = 15'd15360;
    end else if (wrap_q.hue >= 15'd11520) begin
      sec_d.sector = SECTOR_3;
      base         = 15'd11520;
    end else if (wrap_q.hue >= 15'd7680) begin
      sec_d.sector = SECTOR_2;
      base         = 15'd7680;
    end else if (wrap_q.hue >= 15'({3'd0, SECTOR_STEPS})) begin
      sec_d.sector = SECTOR_1;
      base         = 15'({3'd0, SECTOR_STEPS});
    end else begin
      sec_d.sector = SECTOR_0;
      base         = 15'd0;
    end
    sec_d.rem   = 12'(wrap_q.hue - base);
    sec_d.sat   = wrap_q.sat;
    sec_d.val   = wrap_q.val;
    sec_d.alpha = wrap_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (!stall_a) va_q <= valid_i;
      if (!stall_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_a && valid_i) wrap_q <= wrap_d;
    if (!stall_b && va_q)    sec_q  <= sec_d;
  end

  assign valid_o = vb_q;
  assign data_o  = sec_q;

endmodule

// ===== design/hsv2rgb_product.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB products
// Three stages that form the dividends of p, q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_product import hsv2rgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsv_sec_t  data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output hsv_prod_t data_o
);

  // Saturation times hue fraction, and the plain p dividend.
  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [19:0] sr;
    logic [19:0] st;
    logic [15:0] num_p;
  } sfrac_t;

  // Factors in parentheses of q and t, scaled by the denominator.
  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [19:0] xq;
    logic [19:0] xt;
    logic [15:0] num_p;
  } factor_t;

  logic      vc_q, vd_q, ve_q;
  logic      stall_c, stall_d, stall_e;
  sfrac_t    sf_d, sf_q;
  factor_t   fa_d, fa_q;
  hsv_prod_t pr_d, pr_q;
  logic [11:0] comp;
  logic [27:0] full_q, full_t;

  assign stall_e = ve_q && stall_i;
  assign stall_d = vd_q && stall_e;
  assign stall_c = vc_q && stall_d;
  assign stall_o = stall_c;

  always_comb begin
    comp         = SECTOR_STEPS - data_i.rem;
    sf_d.sector  = data_i.sector;
    sf_d.val     = data_i.val;
    sf_d.alpha   = data_i.alpha;
    sf_d.sr      = {12'd0, data_i.sat} * {8'd0, data_i.rem};
    sf_d.st      = {12'd0, data_i.sat} * {8'd0, comp};
    sf_d.num_p   = {8'd0, data_i.val} * {8'd0, FRACTION_ONE - data_i.sat};
  end

  always_comb begin
    fa_d.sector = sf_q.sector;
    fa_d.val    = sf_q.val;
    fa_d.alpha  = sf_q.alpha;
    fa_d.xq     = DEN_QT - sf_q.sr;
    fa_d.xt     = DEN_QT - sf_q.st;
    fa_d.num_p  = sf_q.num_p;
  end

  // The low eight bits of the q and t dividends never reach the quotient.
  always_comb begin
    full_q      = {20'd0, fa_q.val} * {8'd0, fa_q.xq};
    full_t      = {20'd0, fa_q.val} * {8'd0, fa_q.xt};
    pr_d.sector = fa_q.sector;
    pr_d.val    = fa_q.val;
    pr_d.alpha  = fa_q.alpha;
    pr_d.num_q  = full_q[27:8];
    pr_d.num_t  = full_t[27:8];
    pr_d.num_p  = fa_q.num_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (!stall_c) vc_q <= valid_i;
      if (!stall_d) vd_q <= vc_q;
      if (!stall_e) ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_c && valid_i) sf_q <= sf_d;
    if (!stall_d && vc_q)    fa_q <= fa_d;
    if (!stall_e && vd_q)    pr_q <= pr_d;
  end

  assign valid_o = ve_q;
  assign data_o  = pr_q;

endmodule

// ===== design/hsv2rgb_divide.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB constant divider
// Three stages of reciprocal estimate, remainder and one-step correction.
// ----------------------------------------------------------------------------
module hsv2rgb_divide import hsv2rgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsv_prod_t data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output hsv_quot_t data_o
);

  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [19:0] num_q;
    logic [19:0] num_t;
    logic [15:0] num_p;
    logic [7:0]  est_q;
    logic [7:0]  est_t;
    logic [7:0]  est_p;
  } est_t;

  typedef struct packed {
    hsv_sector_e sector;
    logic [7:0]  val;
    logic [7:0]  alpha;
    logic [19:0] rem_q;
    logic [19:0] rem_t;
    logic [15:0] rem_p;
    logic [7:0]  est_q;
    logic [7:0]  est_t;
    logic [7:0]  est_p;
  } rem_t;

  logic      vf_q, vg_q, vh_q;
  logic      stall_f, stall_g, stall_h;
  est_t      es_d, es_q;
  rem_t      rm_d, rm_q;
  hsv_quot_t qu_d, qu_q;
  logic [28:0] prod_q, prod_t;
  logic [23:0] prod_p;

  assign stall_h = vh_q && stall_i;
  assign stall_g = vg_q && stall_h;
  assign stall_f = vf_q && stall_g;
  assign stall_o = stall_f;

  // The estimate is never above the true quotient and at most one below.
  always_comb begin
    prod_q       = {9'd0, data_i.num_q} * {20'd0, RECIP_QT};
    prod_t       = {9'd0, data_i.num_t} * {20'd0, RECIP_QT};
    prod_p       = {8'd0, data_i.num_p} * {15'd0, RECIP_P};
    es_d.sector  = data_i.sector;
    es_d.val     = data_i.val;
    es_d.alpha   = data_i.alpha;
    es_d.num_q   = data_i.num_q;
    es_d.num_t   = data_i.num_t;
    es_d.num_p   = data_i.num_p;
    es_d.est_q   = prod_q[27:20];
    es_d.est_t   = prod_t[27:20];
    es_d.est_p   = prod_p[23:16];
  end

  always_comb begin
    rm_d.sector = es_q.sector;
    rm_d.val    = es_q.val;
    rm_d.alpha  = es_q.alpha;
    rm_d.rem_q  = es_q.num_q - {12'd0, es_q.est_q} * {8'd0, DIV_QT};
    rm_d.rem_t  = es_q.num_t - {12'd0, es_q.est_t} * {8'd0, DIV_QT};
    rm_d.rem_p  = es_q.num_p - {8'd0, es_q.est_p} * {8'd0, FRACTION_ONE};
    rm_d.est_q  = es_q.est_q;
    rm_d.est_t  = es_q.est_t;
    rm_d.est_p  = es_q.est_p;
  end

  always_comb begin
    qu_d.sector = rm_q.sector;
    qu_d.val    = rm_q.val;
    qu_d.alpha  = rm_q.alpha;
    qu_d.q = rm_q.est_q + {7'd0, rm_q.rem_q >= {8'd0, DIV_QT}};
    qu_d.t = rm_q.est_t + {7'd0, rm_q.rem_t >= {8'd0, DIV_QT}};
    qu_d.p = rm_q.est_p + {7'd0, rm_q.rem_p >= {8'd0, FRACTION_ONE}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vh_q <= 1'b0;
    end else begin
      if (!stall_f) vf_q <= valid_i;
      if (!stall_g) vg_q <= vf_q;
      if (!stall_h) vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_f && valid_i) es_q <= es_d;
    if (!stall_g && vf_q)    rm_q <= rm_d;
    if (!stall_h && vg_q)    qu_q <= qu_d;
  end

  assign valid_o = vh_q;
  assign data_o  = qu_q;

endmodule

// ===== design/hsv2rgb_select.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel select
// Orders p, q, t and v by sector into the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_select import hsv2rgb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      stall_o,
  input  hsv_quot_t data_i,
  output logic      valid_o,
  input  logic      stall_i,
  output rgb_out_t  data_o
);

  logic     vo_q;
  logic     stall_out;
  rgb_out_t rgb_d, rgb_q;

  assign stall_out = vo_q && stall_i;
  assign stall_o   = stall_out;

  always_comb begin
    rgb_d.alpha_out = data_i.alpha;
    case (data_i.sector)
      SECTOR_0: begin
        rgb_d.red = data_i.val; rgb_d.green = data_i.t;   rgb_d.blue = data_i.p;
      end
      SECTOR_1: begin
        rgb_d.red = data_i.q;   rgb_d.green = data_i.val; rgb_d.blue = data_i.p;
      end
      SECTOR_2: begin
        rgb_d.red = data_i.p;   rgb_d.green = data_i.val; rgb_d.blue = data_i.t;
      end
      SECTOR_3: begin
        rgb_d.red = data_i.p;   rgb_d.green = data_i.q;   rgb_d.blue = data_i.val;
      end
      SECTOR_4: begin
        rgb_d.red = data_i.t;   rgb_d.green = data_i.p;   rgb_d.blue = data_i.val;
      end
      default: begin
        rgb_d.red = data_i.val; rgb_d.green = data_i.p;   rgb_d.blue = data_i.q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (!stall_out) begin
      vo_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_out && valid_i) rgb_q <= rgb_d;
  end

  assign valid_o = vo_q;
  assign data_o  = rgb_q;

endmodule
